// ===== design/fbpa_pkg.sv =====
package fbpa_pkg;

  // field widths
  localparam int REQ_SIZE_W  = 21;
  localparam int ADDR_W      = 30;
  localparam int ACC_W       = 48;
  localparam int STATUS_W    = 2;
  localparam int SHIFT_W     = 5;
  localparam int LIMIT_W     = 11;
  localparam int CFG_DATA_W  = 11;
  localparam int MARK_W      = REQ_SIZE_W + 1;

  // stream packing
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 272;

  localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 5'd20;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1020;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TOO_LARGE = 2'd1,
    STATUS_NO_MEM    = 2'd2,
    STATUS_BAD_FREE  = 2'd3
  } status_t;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_t;

  typedef enum logic {
    CFG_BLOCK_SHIFT = 1'b0,
    CFG_MAX_BLOCKS  = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  // what the accepted transaction turned out to be
  typedef enum logic [2:0] {
    ACT_TOO_LARGE,
    ACT_POP,
    ACT_GROUP,
    ACT_CARVE,
    ACT_NO_MEM,
    ACT_FREE,
    ACT_BAD_FREE
  } action_t;

endpackage

// ===== design/fixed_block_pool_allocator.sv =====
// Fixed-size block pool allocator. Each input transaction is an allocate (tuser 0) or a free
// (tuser 1) and yields exactly one result transaction carrying a status, the granted block
// offset and five running 48-bit counters. Blocks are 2^block_shift bytes; allocation reuses
// the most recently freed block first, then the remaining blocks of the current group, then
// carves a new group of GROUP_SIZE blocks while it fits under the block limit. A transaction
// is accepted in the idle state, which issues the synchronous reads of the freed-block stack
// and of the outstanding-mark memory, and committed in the execute state, which does the
// read-modify-write and loads the result register; a stalled result output holds the block in
// its execute state. After reset the block clears every outstanding-mark memory entry before
// it accepts its first transaction; configuration writes are taken at any time.
module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS = 1024,
  parameter int GROUP_SIZE = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  // slave side
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [20:0] req_size, [50:21] free_addr, [55:51] zero
  input  logic [fbpa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [0] req_type
  input  logic [0:0]                          s_axis_tuser,
  // master side
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [29:0] block_addr, [77:30] frag_total, [125:78] alloc_count, [173:126] free_count,
  // [221:174] requested_sum, [269:222] granted_area, [271:270] zero
  output logic [fbpa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // [1:0] status
  output logic [fbpa_pkg::STATUS_W-1:0]       m_axis_tuser,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [0:0]                          cfg_addr,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int GL_W  = $clog2(GROUP_SIZE + 1);
  localparam int CMP_W = ((CNT_W > fbpa_pkg::LIMIT_W) ? CNT_W : fbpa_pkg::LIMIT_W) + 1;

  localparam int RW = fbpa_pkg::REQ_SIZE_W;
  localparam int AW = fbpa_pkg::ADDR_W;
  localparam int CW = fbpa_pkg::ACC_W;

  // configuration registers
  logic [fbpa_pkg::SHIFT_W-1:0] block_shift;
  logic [fbpa_pkg::LIMIT_W-1:0] max_blocks;

  // control state
  fbpa_pkg::state_t state, state_next;
  logic [IDX_W-1:0] clr_idx;
  logic [CNT_W-1:0] freed_depth;
  logic [CNT_W-1:0] carved_count;
  logic [GL_W-1:0]  group_left;

  // running counters, shown directly on the result bus
  logic [CW-1:0] frag_acc, alloc_acc, free_acc, size_acc, area_acc;

  // transaction held between accept and commit
  fbpa_pkg::action_t act, act_next;
  logic [RW-1:0]    req;
  logic [IDX_W-1:0] free_idx;

  // result register
  logic                  out_valid;
  fbpa_pkg::status_t     out_status;
  logic [AW-1:0]         out_block_addr;

  // memories
  logic [IDX_W-1:0]            stack_rdata;
  logic                        stack_we, stack_re;
  logic [IDX_W-1:0]            stack_raddr;
  logic [fbpa_pkg::MARK_W-1:0] mark_rdata, mark_wdata;
  logic                        mark_we, mark_re;
  logic [IDX_W-1:0]            mark_waddr;

  // handshake
  logic in_accept, commit, clr_last;

  // input fields
  logic          in_req_type;
  logic [RW-1:0] in_req_size;
  logic [AW-1:0] in_free_addr;

  // derived from configuration
  logic [fbpa_pkg::SHIFT_W-1:0] shift_eff;
  logic [RW-1:0]                bsize;
  logic [CMP_W-1:0]             limit_eff;
  logic [CMP_W-1:0]             carve_sum;

  // accept-side decode
  logic [AW-1:0] free_idx_full;
  logic          free_aligned, free_in_range;

  // commit-side values
  logic [CMP_W-1:0] group_idx_w, carve_idx_w;
  logic [IDX_W-1:0] grant_idx;
  logic             granted, free_ok;
  logic [RW-1:0]    stored_req;

  assign in_req_type  = s_axis_tuser[0];
  assign in_req_size  = s_axis_tdata[RW-1:0];
  assign in_free_addr = s_axis_tdata[RW+AW-1:RW];

  assign shift_eff = (block_shift > fbpa_pkg::SHIFT_MAX) ? fbpa_pkg::SHIFT_MAX : block_shift;
  assign bsize     = RW'(1) << shift_eff;
  assign limit_eff = (CMP_W'(max_blocks) > CMP_W'(MAX_BLOCKS)) ? CMP_W'(MAX_BLOCKS)
                                                                : CMP_W'(max_blocks);
  assign carve_sum = CMP_W'(carved_count) + CMP_W'(GROUP_SIZE);

  // free address checks: block aligned and block number inside the pool
  assign free_idx_full = in_free_addr >> shift_eff;
  assign free_aligned  = (in_free_addr & AW'(bsize - RW'(1))) == '0;
  assign free_in_range = free_idx_full < AW'(MAX_BLOCKS);

  // decide at accept which path the transaction takes
  always_comb begin
    act_next = fbpa_pkg::ACT_NO_MEM;
    if (in_req_type == fbpa_pkg::REQ_FREE) begin
      act_next = (free_aligned && free_in_range) ? fbpa_pkg::ACT_FREE
                                                  : fbpa_pkg::ACT_BAD_FREE;
    end else begin
      priority if (in_req_size > bsize) begin
        act_next = fbpa_pkg::ACT_TOO_LARGE;
      end else if (freed_depth != '0) begin
        act_next = fbpa_pkg::ACT_POP;
      end else if (group_left != '0) begin
        act_next = fbpa_pkg::ACT_GROUP;
      end else if (carve_sum <= limit_eff) begin
        act_next = fbpa_pkg::ACT_CARVE;
      end else begin
        act_next = fbpa_pkg::ACT_NO_MEM;
      end
    end
  end

  // state machine
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    commit        = 1'b0;
    clr_last      = (clr_idx == IDX_W'(MAX_BLOCKS - 1));
    unique case (state)
      fbpa_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_next = fbpa_pkg::ST_IDLE;
        end
      end
      fbpa_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = fbpa_pkg::ST_EXEC;
        end
      end
      fbpa_pkg::ST_EXEC: begin
        // result register must be empty or emptying this cycle
        if (!out_valid || m_axis_tready) begin
          commit     = 1'b1;
          state_next = fbpa_pkg::ST_IDLE;
        end
      end
      default: state_next = fbpa_pkg::ST_CLEAR;
    endcase
  end

  assign in_accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= fbpa_pkg::ST_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == fbpa_pkg::ST_CLEAR) begin
        clr_idx <= clr_idx + IDX_W'(1);
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      block_shift <= fbpa_pkg::SHIFT_RESET;
      max_blocks  <= fbpa_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        fbpa_pkg::CFG_BLOCK_SHIFT: block_shift <= cfg_wdata[fbpa_pkg::SHIFT_W-1:0];
        fbpa_pkg::CFG_MAX_BLOCKS:  max_blocks  <= cfg_wdata[fbpa_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // capture the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      act <= fbpa_pkg::ACT_NO_MEM;
    end else if (in_accept) begin
      act <= act_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req      <= in_req_size;
      free_idx <= free_idx_full[IDX_W-1:0];
    end
  end

  // stack pop reads the top entry, a free reads the mark of its block
  assign stack_re    = in_accept && (act_next == fbpa_pkg::ACT_POP);
  assign stack_raddr = IDX_W'(freed_depth - CNT_W'(1));
  assign mark_re     = in_accept && (act_next == fbpa_pkg::ACT_FREE);

  // block number of a grant: newest free, else highest untaken block of the group
  assign group_idx_w = CMP_W'(carved_count) - CMP_W'(GROUP_SIZE) + CMP_W'(group_left)
                       - CMP_W'(1);
  assign carve_idx_w = carve_sum - CMP_W'(1);

  always_comb begin
    unique case (act)
      fbpa_pkg::ACT_POP:   grant_idx = stack_rdata;
      fbpa_pkg::ACT_GROUP: grant_idx = group_idx_w[IDX_W-1:0];
      fbpa_pkg::ACT_CARVE: grant_idx = carve_idx_w[IDX_W-1:0];
      default:             grant_idx = free_idx;
    endcase
  end

  assign granted    = (act == fbpa_pkg::ACT_POP) || (act == fbpa_pkg::ACT_GROUP) ||
                      (act == fbpa_pkg::ACT_CARVE);
  assign free_ok    = (act == fbpa_pkg::ACT_FREE) && mark_rdata[fbpa_pkg::MARK_W-1];
  assign stored_req = mark_rdata[RW-1:0];

  // freed block goes on the stack while there is room
  assign stack_we = commit && free_ok && (freed_depth < CNT_W'(MAX_BLOCKS));

  // mark memory: clearing pass after reset, set on grant, cleared on a good free
  always_comb begin
    mark_we    = 1'b0;
    mark_waddr = grant_idx;
    mark_wdata = {1'b0, stored_req};
    if (state == fbpa_pkg::ST_CLEAR) begin
      mark_we    = 1'b1;
      mark_waddr = clr_idx;
      mark_wdata = '0;
    end else if (commit && granted) begin
      mark_we    = 1'b1;
      mark_wdata = {1'b1, req};
    end else if (commit && free_ok) begin
      mark_we    = 1'b1;
    end
  end

  // pool state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      freed_depth  <= '0;
      carved_count <= '0;
      group_left   <= '0;
      frag_acc     <= '0;
      alloc_acc    <= '0;
      free_acc     <= '0;
      size_acc     <= '0;
      area_acc     <= '0;
    end else if (commit) begin
      if (granted) begin
        alloc_acc <= alloc_acc + CW'(1);
        frag_acc  <= frag_acc + CW'(bsize) - CW'(req);
        size_acc  <= size_acc + CW'(req);
        area_acc  <= area_acc + CW'(bsize);
      end
      unique case (act)
        fbpa_pkg::ACT_POP: begin
          freed_depth <= freed_depth - CNT_W'(1);
        end
        fbpa_pkg::ACT_GROUP: begin
          group_left <= group_left - GL_W'(1);
        end
        fbpa_pkg::ACT_CARVE: begin
          carved_count <= carve_sum[CNT_W-1:0];
          group_left   <= GL_W'(GROUP_SIZE - 1);
        end
        fbpa_pkg::ACT_FREE: begin
          if (free_ok) begin
            free_acc <= free_acc + CW'(1);
            // uses the current block size, even if the shift changed meanwhile
            frag_acc <= frag_acc - (CW'(bsize) - CW'(stored_req));
            if (stack_we) begin
              freed_depth <= freed_depth + CNT_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_block_addr <= granted ? (AW'(grant_idx) << shift_eff) : '0;
      unique case (act)
        fbpa_pkg::ACT_TOO_LARGE: out_status <= fbpa_pkg::STATUS_TOO_LARGE;
        fbpa_pkg::ACT_NO_MEM:    out_status <= fbpa_pkg::STATUS_NO_MEM;
        fbpa_pkg::ACT_BAD_FREE:  out_status <= fbpa_pkg::STATUS_BAD_FREE;
        fbpa_pkg::ACT_FREE:      out_status <= free_ok ? fbpa_pkg::STATUS_OK
                                                       : fbpa_pkg::STATUS_BAD_FREE;
        default:                 out_status <= fbpa_pkg::STATUS_OK;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {2'b00, area_acc, size_acc, free_acc, alloc_acc, frag_acc,
                          out_block_addr};

  // freed-block stack
  fbpa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_BLOCKS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stack_we),
    .waddr (freed_depth[IDX_W-1:0]),
    .wdata (free_idx),
    .re    (stack_re),
    .raddr (stack_raddr),
    .rdata (stack_rdata)
  );

  // outstanding mark and stored request size, one entry per block
  fbpa_ram #(
    .WIDTH (fbpa_pkg::MARK_W),
    .DEPTH (MAX_BLOCKS)
  ) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .re    (mark_re),
    .raddr (free_idx_full[IDX_W-1:0]),
    .rdata (mark_rdata)
  );

`ifndef ASSERT_OFF
  // an accepted transaction is worked on in the very next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == fbpa_pkg::ST_EXEC))
    else $error("accepted transaction did not enter execution");

  // stack depth and carved blocks never pass the pool size
  a_pool_bounds: assert property (@(posedge clk) disable iff (rst)
    (freed_depth <= CNT_W'(MAX_BLOCKS)) && (carved_count <= CNT_W'(MAX_BLOCKS)))
    else $error("pool bookkeeping out of range");

  // group count stays within a group
  a_group_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(group_left) < CMP_W'(GROUP_SIZE) || group_left == '0)
    else $error("group count out of range");

  // a refused or free result never carries an address
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status != fbpa_pkg::STATUS_OK)) |-> (out_block_addr == '0))
    else $error("refused result carries an address");
`endif

endmodule

// ===== design/fbpa_ram.sv =====
module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
